// ===== hdl/swsend_pkg.sv =====
// shared types and codes for the sliding-window sender
package swsend_pkg;

  localparam int ID_W = 24;

  // bytes per packet on the wire, a power of two so the window math stays shifts
  localparam int PKT_BYTES = 1024;

  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_CORRUPT = 2'd2;
  localparam logic [1:0] CMD_TIMEOUT = 2'd3;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FIN   = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  localparam logic [1:0] MARK_NONE  = 2'd0;
  localparam logic [1:0] MARK_SENT  = 2'd1;
  localparam logic [1:0] MARK_ACKED = 2'd2;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_RETRY  = 1'b1;

  localparam logic [15:0] WINDOW_RESET = 16'd1000;
  localparam logic [3:0]  RETRY_RESET  = 4'd5;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [ID_W-1:0] seq_number;
    logic [ID_W-1:0] packet_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] packet_id;
    logic [31:0]     byte_offset;
    logic [15:0]     payload_size;
    logic            final_packet;
    logic            last_of_run;
  } out_item_t;

endpackage

// ===== hdl/sliding_window_sender_top.sv =====
// sliding-window ARQ sender: mark ring, window sequencer and output stage
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_valid / in_stall    | in_item_t (cmd, seq_number, packet_count)
//  out_    | out | out_valid / out_stall  | out_item_t (kind, id, offset, size, flags)
//  cfg     | in  | psel/penable/pwrite    | window_bytes @0, retry_limit @4
//
// one request at a time; a corrupt notice clears the retry count and the sequencer stays idle
// request/ack: accept, mark, window advance (ring memory read then check per retired packet,
// then a stop), window check, offset divider, window slot scan (ring memory read then check)
// and wrap-up; FIN skips divider and scan
// timeout: accept, the same divider and scan, the retry count, then wrap-up
// downstream stall holds the scan; reset clears ring valid bits at once, no sweep
module sliding_window_sender_top
  import swsend_pkg::*;
#(
  parameter int HDR_BYTES  = 16,
  parameter int RING_DEPTH = 64,
  parameter int MAX_WINDOW = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int ADV_W  = $clog2(RING_DEPTH + 1);
  localparam int I_W    = $clog2(MAX_WINDOW + 1);
  localparam int MAX_PK = (65535 + PKT_BYTES - 1) / PKT_BYTES;
  localparam int PK_W   = $clog2(MAX_PK + 1);
  localparam logic [15:0] PAY_FULL = 16'(PKT_BYTES - HDR_BYTES);
  localparam logic [16:0] PKT_M1   = 17'(PKT_BYTES - 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MARK     = 4'd1;
  localparam logic [3:0] ST_ADV_RD   = 4'd2;
  localparam logic [3:0] ST_ADV_CHK  = 4'd3;
  localparam logic [3:0] ST_AFTER    = 4'd4;
  localparam logic [3:0] ST_DIV_GO   = 4'd5;
  localparam logic [3:0] ST_DIV_WAIT = 4'd6;
  localparam logic [3:0] ST_EMIT_RD  = 4'd7;
  localparam logic [3:0] ST_EMIT_CHK = 4'd8;
  localparam logic [3:0] ST_ABORT    = 4'd9;
  localparam logic [3:0] ST_FINISH   = 4'd10;

  // configuration
  logic [15:0] wb_r;
  logic [3:0]  rl_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_RETRY) ? {28'd0, rl_r} : {16'd0, wb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= WINDOW_RESET;
      rl_r <= RETRY_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WINDOW) wb_r <= pwdata[15:0];
      else                        rl_r <= pwdata[3:0];
    end
  end

  // window geometry from window_bytes
  logic [PK_W-1:0] pk;
  logic [I_W-1:0]  win;
  logic [15:0]     rem_b;
  logic [15:0]     diff_b;
  logic            small_win;
  logic [15:0]     sat_wb, sat_rem;

  always_comb begin
    pk        = PK_W'(({1'b0, wb_r} + PKT_M1) / PKT_BYTES);
    win       = (pk > PK_W'(MAX_WINDOW)) ? I_W'(MAX_WINDOW) : I_W'(pk);
    rem_b     = 16'(wb_r % PKT_BYTES);
    diff_b    = 16'(PKT_BYTES) - rem_b;
    small_win = ({1'b0, wb_r} <= 17'(PKT_BYTES));
    sat_wb    = (wb_r > 16'(HDR_BYTES)) ? wb_r - 16'(HDR_BYTES) : 16'd0;
    sat_rem   = (rem_b > 16'(HDR_BYTES)) ? rem_b - 16'(HDR_BYTES) : 16'd0;
  end

  // mark ring: data in memory, valid bits in flops
  logic [1:0]            mark_mem [RING_DEPTH];
  logic                  mem_we, mem_re;
  logic [SLOT_W-1:0]     mem_waddr, mem_raddr;
  logic [1:0]            mem_wdata;
  logic [1:0]            mem_rd_r;
  logic                  rd_vld_r;
  logic [RING_DEPTH-1:0] valid_r, valid_nxt;
  logic [1:0]            mark_q;

  always_ff @(posedge clk) begin
    if (mem_we) mark_mem[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      mem_rd_r <= mark_mem[mem_raddr];
      rd_vld_r <= valid_r[mem_raddr];
    end
  end

  assign mark_q = rd_vld_r ? mem_rd_r : MARK_NONE;

  // divider handshake for the offset correction term
  logic            div_start, div_done;
  logic [ID_W-1:0] div_quot;
  logic [PK_W-1:0] div_rem;

  // sequencer state
  logic [3:0]        state_r, state_nxt;
  logic [ID_W-1:0]   seq_r, seq_nxt;
  logic              resend_r, resend_nxt;
  logic [ID_W:0]     base_r, base_nxt;
  logic [SLOT_W-1:0] bslot_r, bslot_nxt;
  logic [ID_W-1:0]   last_r, last_nxt;
  logic              started_r, started_nxt;
  logic [3:0]        retry_r, retry_nxt;
  logic [ADV_W-1:0]  adv_r, adv_nxt;
  logic [I_W-1:0]    idx_r, idx_nxt;
  logic [ID_W:0]     id_r, id_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ID_W-1:0]   d_r, d_nxt;
  logic [ID_W-1:0]   q_r, q_nxt;
  logic [PK_W-1:0]   r_r, r_nxt;
  logic [31:0]       prod_a_r, prod_a_nxt, prod_b_r, prod_b_nxt;
  logic [15:0]       size_r, size_nxt;
  logic              pend_v_r, pend_v_nxt;
  out_item_t         pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt;
  out_item_t         out_r, out_nxt;

  logic              out_free, push;
  out_item_t         push_item, data_item, ctl_item;
  logic [ID_W:0]     seq_dist;
  logic [SLOT_W:0]   seq_slot_sum;
  logic [SLOT_W-1:0] seq_slot;
  logic              seq_in;
  logic [ID_W+15:0]  mul_a, mul_b;
  logic [15:0]       mul_a_k;
  logic              size_hit, emit;
  logic [3:0]        retry_inc;

  swsend_div #(.DEN_W(PK_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (ID_W'(base_r - 1'b1)),
    .den   (pk),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  assign out_free  = !out_v_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    data_item              = '0;
    data_item.kind         = KIND_DATA;
    data_item.packet_id    = id_r[ID_W-1:0];
    data_item.byte_offset  = prod_a_r - prod_b_r;
    data_item.payload_size = size_r;
    data_item.final_packet = (id_r == {1'b0, last_r});
    ctl_item               = '0;
  end

  always_comb begin
    seq_dist     = {1'b0, seq_r} - base_r;
    seq_in       = ({1'b0, seq_r} >= base_r) && (seq_dist < (ID_W+1)'(RING_DEPTH)) &&
                   (seq_r <= last_r);
    seq_slot_sum = {1'b0, bslot_r} + {1'b0, seq_dist[SLOT_W-1:0]};
    seq_slot     = (seq_slot_sum >= (SLOT_W+1)'(RING_DEPTH)) ?
                   SLOT_W'(seq_slot_sum - (SLOT_W+1)'(RING_DEPTH)) : SLOT_W'(seq_slot_sum);
    mul_a_k      = small_win ? sat_wb : PAY_FULL;
    mul_a        = d_r * mul_a_k;
    mul_b        = small_win ? '0 : (q_r * diff_b);
    size_hit     = (d_r == {ID_W{1'b1}}) || (r_r == pk - 1'b1);
    retry_inc    = retry_r + 4'd1;
  end

  always_comb begin
    state_nxt   = state_r;
    seq_nxt     = seq_r;
    resend_nxt  = resend_r;
    base_nxt    = base_r;
    bslot_nxt   = bslot_r;
    last_nxt    = last_r;
    started_nxt = started_r;
    retry_nxt   = retry_r;
    adv_nxt     = adv_r;
    idx_nxt     = idx_r;
    id_nxt      = id_r;
    slot_nxt    = slot_r;
    d_nxt       = d_r;
    q_nxt       = q_r;
    r_nxt       = r_r;
    prod_a_nxt  = prod_a_r;
    prod_b_nxt  = prod_b_r;
    size_nxt    = size_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    valid_nxt   = valid_r;
    mem_we      = 1'b0;
    mem_waddr   = slot_r;
    mem_wdata   = MARK_SENT;
    mem_re      = 1'b0;
    mem_raddr   = slot_r;
    div_start   = 1'b0;
    push        = 1'b0;
    push_item   = pend_r;
    emit        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          seq_nxt    = in_data.seq_number;
          resend_nxt = 1'b0;
          unique case (in_data.cmd)
            CMD_CORRUPT: retry_nxt = '0;
            CMD_TIMEOUT: begin
              resend_nxt = 1'b1;
              if (started_r && (base_r > {1'b0, last_r})) begin
                pend_v_nxt    = 1'b1;
                pend_nxt      = ctl_item;
                pend_nxt.kind = KIND_FIN;
                state_nxt     = ST_FINISH;
              end else if (started_r) begin
                state_nxt = ST_DIV_GO;
              end else begin
                state_nxt = ST_ABORT;
              end
            end
            CMD_REQUEST: begin
              valid_nxt   = '0;
              base_nxt    = '0;
              bslot_nxt   = '0;
              last_nxt    = in_data.packet_count;
              started_nxt = 1'b1;
              retry_nxt   = '0;
              state_nxt   = ST_MARK;
            end
            CMD_ACK: begin
              if (started_r) begin
                retry_nxt = '0;
                state_nxt = ST_MARK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        if (seq_in) begin
          mem_we              = 1'b1;
          mem_waddr           = seq_slot;
          mem_wdata           = MARK_ACKED;
          valid_nxt[seq_slot] = 1'b1;
        end
        adv_nxt   = '0;
        state_nxt = ST_ADV_RD;
      end
      ST_ADV_RD: begin
        if ((adv_r == ADV_W'(RING_DEPTH)) || (base_r > {1'b0, last_r})) begin
          state_nxt = ST_AFTER;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = bslot_r;
          state_nxt = ST_ADV_CHK;
        end
      end
      ST_ADV_CHK: begin
        if (mark_q == MARK_ACKED) begin
          valid_nxt[bslot_r] = 1'b0;
          base_nxt           = base_r + 1'b1;
          bslot_nxt          = (bslot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : bslot_r + 1'b1;
          adv_nxt            = adv_r + 1'b1;
          state_nxt          = ST_ADV_RD;
        end else begin
          state_nxt = ST_AFTER;
        end
      end
      ST_AFTER: begin
        if (base_r > {1'b0, last_r}) begin
          pend_v_nxt    = 1'b1;
          pend_nxt      = ctl_item;
          pend_nxt.kind = KIND_FIN;
          state_nxt     = ST_FINISH;
        end else begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          idx_nxt   = '0;
          id_nxt    = base_r;
          slot_nxt  = bslot_r;
          d_nxt     = ID_W'(base_r - 1'b1);
          q_nxt     = div_quot;
          r_nxt     = div_rem;
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        if ((idx_r == win) || (id_r > {1'b0, last_r})) begin
          state_nxt = resend_r ? ST_ABORT : ST_FINISH;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = slot_r;
          prod_a_nxt = mul_a[31:0];
          prod_b_nxt = mul_b[31:0];
          if (small_win)     size_nxt = sat_wb;
          else if (size_hit) size_nxt = (rem_b == 16'd0) ? PAY_FULL : sat_rem;
          else               size_nxt = PAY_FULL;
          state_nxt = ST_EMIT_CHK;
        end
      end
      ST_EMIT_CHK: begin
        emit = resend_r || (mark_q == MARK_NONE);
        // hold the scan while the staged result cannot move on
        if (!(emit && pend_v_r && !out_free)) begin
          if (emit) begin
            push       = pend_v_r;
            pend_v_nxt = 1'b1;
            pend_nxt   = data_item;
            if (!resend_r) begin
              mem_we            = 1'b1;
              mem_waddr         = slot_r;
              mem_wdata         = MARK_SENT;
              valid_nxt[slot_r] = 1'b1;
            end
          end
          idx_nxt  = idx_r + 1'b1;
          id_nxt   = id_r + 1'b1;
          slot_nxt = (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;
          d_nxt    = d_r + 1'b1;
          if (d_r == {ID_W{1'b1}}) begin
            q_nxt = '0;
            r_nxt = '0;
          end else if (r_r == pk - 1'b1) begin
            q_nxt = q_r + 1'b1;
            r_nxt = '0;
          end else begin
            r_nxt = r_r + 1'b1;
          end
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_ABORT: begin
        if (retry_inc >= rl_r) begin
          if (!(pend_v_r && !out_free)) begin
            push          = pend_v_r;
            pend_v_nxt    = 1'b1;
            pend_nxt      = ctl_item;
            pend_nxt.kind = KIND_ABORT;
            valid_nxt     = '0;
            base_nxt      = '0;
            bslot_nxt     = '0;
            last_nxt      = '0;
            started_nxt   = 1'b0;
            retry_nxt     = '0;
            state_nxt     = ST_FINISH;
          end
        end else begin
          retry_nxt = retry_inc;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          push                  = 1'b1;
          push_item.last_of_run = 1'b1;
          pend_v_nxt            = 1'b0;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r && out_stall;
    out_nxt   = out_r;
    if (push) begin
      out_v_nxt = 1'b1;
      out_nxt   = push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      base_r    <= '0;
      bslot_r   <= '0;
      last_r    <= '0;
      started_r <= 1'b0;
      retry_r   <= '0;
      valid_r   <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      base_r    <= base_nxt;
      bslot_r   <= bslot_nxt;
      last_r    <= last_nxt;
      started_r <= started_nxt;
      retry_r   <= retry_nxt;
      valid_r   <= valid_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
    seq_r    <= seq_nxt;
    resend_r <= resend_nxt;
    adv_r    <= adv_nxt;
    idx_r    <= idx_nxt;
    id_r     <= id_nxt;
    slot_r   <= slot_nxt;
    d_r      <= d_nxt;
    q_r      <= q_nxt;
    r_r      <= r_nxt;
    prod_a_r <= prod_a_nxt;
    prod_b_r <= prod_b_nxt;
    size_r   <= size_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  // nothing may stay staged once the sequencer is back to idle
  a_pend_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ST_IDLE && pend_v_r))
    else $error("staged result left behind at idle");

  // the base never runs more than one past the last packet
  a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (base_r <= {1'b0, last_r} + 1'b1))
    else $error("window base past last packet plus one");

  // the base slot pointer stays inside the ring
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bslot_r < SLOT_W'(RING_DEPTH - 1)) || (bslot_r == SLOT_W'(RING_DEPTH - 1)))
    else $error("base slot outside ring");

  // an abort leaves the transfer closed
  a_abort_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ABORT && state_nxt == ST_FINISH && retry_inc >= rl_r) |=>
      (!started_r && base_r == '0))
    else $error("abort did not clear the transfer");

endmodule

// ===== hdl/swsend_div.sv =====
// restoring divider, one quotient bit per cycle
module swsend_div
  import swsend_pkg::*;
#(
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ID_W-1:0]  num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [ID_W-1:0]  quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(ID_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [ID_W-1:0]  quot_r, quot_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    trial    = {rem_r[DEN_W-1:0], quot_r[ID_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ID_W);
      quot_nxt = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt  = trial - {1'b0, den};
        quot_nxt = {quot_r[ID_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial;
        quot_nxt = {quot_r[ID_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r[DEN_W-1:0];

endmodule
